@@ rtl/vtt_pkg.sv @@
// shared types and constants for the value text tokenizer
`timescale 1ns / 1ps

package vtt_pkg;

    localparam int VTT_MAX_NEST  = 255;
    localparam int VTT_LINE_BITS = 24;
    localparam int VTT_LINE_OUT  = 24;

    localparam logic [7:0] CHAR_END        = 8'd0;
    localparam logic [7:0] CHAR_TAB        = 8'd9;
    localparam logic [7:0] CHAR_LF         = 8'd10;
    localparam logic [7:0] CHAR_CR         = 8'd13;
    localparam logic [7:0] CHAR_FIRST_PRNT = 8'd33;
    localparam logic [7:0] CHAR_LAST_PRNT  = 8'd126;
    localparam logic [7:0] CHAR_QUOTE      = 8'd34;
    localparam logic [7:0] CHAR_LBRACK     = 8'd91;
    localparam logic [7:0] CHAR_BSLASH     = 8'd92;
    localparam logic [7:0] CHAR_RBRACK     = 8'd93;
    localparam logic [7:0] CHAR_LC_N       = 8'd110;
    localparam logic [7:0] CHAR_LC_R       = 8'd114;
    localparam logic [7:0] CHAR_LC_T       = 8'd116;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_BARE = 3'd1,
        MODE_STR  = 3'd2,
        MODE_ESC  = 3'd3,
        MODE_ARR  = 3'd4,
        MODE_DROP = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_TOKEN = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_EOI   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        TTYPE_BARE = 2'd0,
        TTYPE_STR  = 2'd1,
        TTYPE_ARR  = 2'd2
    } t_ttype;

    typedef enum logic [1:0] {
        ERR_EOI   = 2'd0,
        ERR_EOL   = 2'd1,
        ERR_DEPTH = 2'd2
    } t_err;

    typedef struct packed {
        t_kind                    kind;
        logic [7:0]               data;
        t_ttype                   ttype;
        t_err                     err;
        logic [VTT_LINE_OUT-1:0]  line;
        logic                     last;
    } t_result;

endpackage

@@ rtl/value_text_tokenizer.sv @@
// value text tokenizer top level: byte stream in, token events out
`timescale 1ns / 1ps

// one text byte enters per slave transaction on s_axis (tdata[7:0]); a zero
// byte ends the input. each byte gives zero, one or two result transactions
// on m_axis: token bytes, token ends, errors and an end of input event.
// tlast marks the final result of a byte.
// the byte is decoded against the scan state in the cycle it is accepted and
// its results are written into a four entry result queue; m_axis is driven
// from the head of that registered queue.
// throughput is one byte per cycle while the receiver keeps up; the queue
// accepts a byte whenever it holds at most two results, so only a stalled
// receiver slows the input.
// when the receiver stalls, results wait in the queue and s_axis_tready drops
// once the queue could not take two more.
// reset (synchronous, active low) empties the queue, returns to idle with
// depth zero and loads the line counter from base_line, which resets to 0.
// a write on i_cfg_wen/i_cfg_wdata sets base_line and reloads the counter;
// it is meant for an idle block.
module value_text_tokenizer #(
    parameter int MAX_NEST  = vtt_pkg::VTT_MAX_NEST,
    parameter int LINE_BITS = vtt_pkg::VTT_LINE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [23:0] i_cfg_wdata,   // base_line
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0], error_code[9:8], line_number[33:10], zero fill[39:34]
    output logic [39:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser,  // event_kind[1:0], token_type[3:2]
    output logic        m_axis_tlast
);

    localparam int DEPTH_W = $clog2(MAX_NEST + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NEST);
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    logic [23:0]           r_base;
    vtt_pkg::t_mode        r_mode, n_mode;
    logic [DEPTH_W-1:0]    r_depth, n_depth;
    logic [LINE_BITS-1:0]  r_line, n_line;
    logic [LINE_BITS-1:0]  line_upd, line_inc, cfg_load, base_load;
    logic [DEPTH_W-1:0]    depth_dec;

    vtt_pkg::t_result      r_queue [QDEPTH];
    logic [QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]       r_count;

    vtt_pkg::t_result      res0, res1;
    logic [1:0]            nres;
    logic                  in_fire, out_fire, printable, is_end;
    logic [7:0]            b, esc_byte;
    vtt_pkg::t_result      head;

    assign b         = s_axis_tdata;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign printable = b inside {[vtt_pkg::CHAR_FIRST_PRNT : vtt_pkg::CHAR_LAST_PRNT]};
    assign is_end    = (b == vtt_pkg::CHAR_END);
    assign line_inc  = (r_line != LINE_MAX) ? r_line + 1'b1 : r_line;
    assign depth_dec = (r_depth != '0) ? r_depth - 1'b1 : r_depth;

    // base line load, saturated to the counter width
    assign cfg_load  = (32'(i_cfg_wdata) > 32'(LINE_MAX)) ? LINE_MAX
                                                            : LINE_BITS'(i_cfg_wdata);
    assign base_load = (32'(r_base) > 32'(LINE_MAX)) ? LINE_MAX : LINE_BITS'(r_base);

    always_comb begin
        case (b)
            vtt_pkg::CHAR_LC_T: esc_byte = vtt_pkg::CHAR_TAB;
            vtt_pkg::CHAR_LC_R: esc_byte = vtt_pkg::CHAR_CR;
            vtt_pkg::CHAR_LC_N: esc_byte = vtt_pkg::CHAR_LF;
            default:            esc_byte = b;
        endcase
    end

    // next scan state
    always_comb begin
        n_mode   = r_mode;
        n_depth  = r_depth;
        line_upd = r_line;
        if (is_end) begin
            n_mode  = vtt_pkg::MODE_IDLE;
            n_depth = '0;
        end else begin
            case (r_mode)
                vtt_pkg::MODE_BARE: begin
                    if (!printable) begin
                        if (b == vtt_pkg::CHAR_LF) begin
                            line_upd = line_inc;
                        end
                        n_mode = vtt_pkg::MODE_IDLE;
                    end
                end
                vtt_pkg::MODE_STR: begin
                    if (b == vtt_pkg::CHAR_QUOTE) begin
                        n_mode = vtt_pkg::MODE_IDLE;
                    end else if (b == vtt_pkg::CHAR_LF) begin
                        n_mode = vtt_pkg::MODE_DROP;
                    end else if (b == vtt_pkg::CHAR_BSLASH) begin
                        n_mode = vtt_pkg::MODE_ESC;
                    end
                end
                vtt_pkg::MODE_ESC: begin
                    n_mode = (b == vtt_pkg::CHAR_LF) ? vtt_pkg::MODE_DROP : vtt_pkg::MODE_STR;
                end
                vtt_pkg::MODE_ARR: begin
                    if (b == vtt_pkg::CHAR_LF) begin
                        line_upd = line_inc;
                    end
                    if (b == vtt_pkg::CHAR_LBRACK) begin
                        if (r_depth >= DEPTH_MAX) begin
                            n_mode = vtt_pkg::MODE_DROP;
                        end else begin
                            n_depth = r_depth + 1'b1;
                        end
                    end else if (b == vtt_pkg::CHAR_RBRACK) begin
                        n_depth = depth_dec;
                        if (depth_dec == '0) begin
                            n_mode = vtt_pkg::MODE_IDLE;
                        end
                    end
                end
                vtt_pkg::MODE_DROP: begin
                    n_mode = vtt_pkg::MODE_DROP;
                end
                default: begin
                    if (!printable) begin
                        if (b == vtt_pkg::CHAR_LF) begin
                            line_upd = line_inc;
                        end
                        n_mode = vtt_pkg::MODE_IDLE;
                    end else if (b == vtt_pkg::CHAR_LBRACK) begin
                        n_depth = DEPTH_W'(1);
                        n_mode  = vtt_pkg::MODE_ARR;
                    end else if (b == vtt_pkg::CHAR_QUOTE) begin
                        n_mode = vtt_pkg::MODE_STR;
                    end else begin
                        n_mode = vtt_pkg::MODE_BARE;
                    end
                end
            endcase
        end
        n_line = is_end ? base_load : line_upd;
    end

    // results of the accepted byte
    always_comb begin
        nres       = 2'd0;
        res0.kind  = vtt_pkg::KIND_BYTE;
        res0.data  = 8'd0;
        res0.ttype = vtt_pkg::TTYPE_BARE;
        res0.err   = vtt_pkg::ERR_EOI;
        res0.line  = vtt_pkg::VTT_LINE_OUT'(line_upd);
        res0.last  = 1'b1;
        res1       = res0;
        res1.kind  = vtt_pkg::KIND_EOI;
        if (is_end) begin
            case (r_mode)
                vtt_pkg::MODE_BARE: begin
                    nres      = 2'd2;
                    res0.kind = vtt_pkg::KIND_TOKEN;
                end
                vtt_pkg::MODE_STR, vtt_pkg::MODE_ESC: begin
                    nres       = 2'd2;
                    res0.kind  = vtt_pkg::KIND_ERROR;
                    res0.ttype = vtt_pkg::TTYPE_STR;
                end
                vtt_pkg::MODE_ARR: begin
                    nres       = 2'd2;
                    res0.kind  = vtt_pkg::KIND_ERROR;
                    res0.ttype = vtt_pkg::TTYPE_ARR;
                end
                default: begin
                    nres      = 2'd1;
                    res0.kind = vtt_pkg::KIND_EOI;
                end
            endcase
            res0.last = (nres == 2'd1);
        end else begin
            case (r_mode)
                vtt_pkg::MODE_BARE: begin
                    nres = 2'd1;
                    if (printable) begin
                        res0.data = b;
                    end else begin
                        res0.kind = vtt_pkg::KIND_TOKEN;
                    end
                end
                vtt_pkg::MODE_STR: begin
                    res0.ttype = vtt_pkg::TTYPE_STR;
                    if (b == vtt_pkg::CHAR_QUOTE) begin
                        nres      = 2'd1;
                        res0.kind = vtt_pkg::KIND_TOKEN;
                    end else if (b == vtt_pkg::CHAR_LF) begin
                        nres      = 2'd1;
                        res0.kind = vtt_pkg::KIND_ERROR;
                        res0.err  = vtt_pkg::ERR_EOL;
                    end else if (b != vtt_pkg::CHAR_BSLASH) begin
                        nres      = 2'd1;
                        res0.data = b;
                    end
                end
                vtt_pkg::MODE_ESC: begin
                    nres       = 2'd1;
                    res0.ttype = vtt_pkg::TTYPE_STR;
                    if (b == vtt_pkg::CHAR_LF) begin
                        res0.kind = vtt_pkg::KIND_ERROR;
                        res0.err  = vtt_pkg::ERR_EOL;
                    end else begin
                        res0.data = esc_byte;
                    end
                end
                vtt_pkg::MODE_ARR: begin
                    nres       = 2'd1;
                    res0.ttype = vtt_pkg::TTYPE_ARR;
                    if (b == vtt_pkg::CHAR_LBRACK && r_depth >= DEPTH_MAX) begin
                        res0.kind = vtt_pkg::KIND_ERROR;
                        res0.err  = vtt_pkg::ERR_DEPTH;
                    end else if (b == vtt_pkg::CHAR_RBRACK && depth_dec == '0) begin
                        res0.kind = vtt_pkg::KIND_TOKEN;
                    end else begin
                        res0.data = b;
                    end
                end
                vtt_pkg::MODE_DROP: begin
                    nres = 2'd0;
                end
                default: begin
                    if (printable && b != vtt_pkg::CHAR_LBRACK && b != vtt_pkg::CHAR_QUOTE) begin
                        nres      = 2'd1;
                        res0.data = b;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_mode  <= vtt_pkg::MODE_IDLE;
            r_depth <= '0;
            r_line  <= '0;
        end else if (i_cfg_wen) begin
            r_base <= i_cfg_wdata;
            r_line <= cfg_load;
        end else if (in_fire) begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
            r_line  <= n_line;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (in_fire && nres != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (in_fire && nres == 2'd2) begin
            r_queue[r_wr_ptr + 1'b1] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_fire) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(nres);
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (in_fire ? (QPTR_W + 1)'(nres) : '0)
                               - (QPTR_W + 1)'(out_fire);
        end
    end

    assign s_axis_tready = (r_count <= (QPTR_W + 1)'(QDEPTH - 2));
    assign m_axis_tvalid = (r_count != '0);
    assign head          = r_queue[r_rd_ptr];
    assign m_axis_tdata  = {6'b000000, head.line, head.err, head.data};
    assign m_axis_tuser  = {head.ttype, head.kind};
    assign m_axis_tlast  = head.last;

endmodule
